FILE: hw/rtl/iba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types and constants for the image border address core.
// ----------------------------------------------------------------------------
package iba_pkg;

    localparam int IBA_COORD_W        = 16;
    localparam int IBA_INDEX_W        = 24;
    localparam int IBA_SIZE_W         = 13;
    localparam int IBA_CFG_ADDR_W     = 2;
    localparam int IBA_CFG_DATA_W     = 13;
    localparam int IBA_MAX_DIM_DEF    = 4096;
    localparam int IBA_COORD_BITS_DEF = 16;

    localparam logic [IBA_SIZE_W-1:0] IBA_SIZE_RST = 13'd4096;

    localparam logic [IBA_CFG_ADDR_W-1:0] IBA_REG_MODE   = 2'd0;
    localparam logic [IBA_CFG_ADDR_W-1:0] IBA_REG_WIDTH  = 2'd1;
    localparam logic [IBA_CFG_ADDR_W-1:0] IBA_REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        IBA_MODE_ZERO    = 2'd0,
        IBA_MODE_EDGE    = 2'd1,
        IBA_MODE_REPEAT  = 2'd2,
        IBA_MODE_REFLECT = 2'd3
    } iba_mode_t;

    typedef struct packed {
        logic signed [IBA_COORD_W-1:0] col;
        logic signed [IBA_COORD_W-1:0] row;
    } iba_in_t;

    typedef struct packed {
        logic [IBA_INDEX_W-1:0] source_index;
        logic                   is_padding;
    } iba_out_t;

endpackage

FILE: hw/rtl/image_border_address_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_border_address_core
// Maps a signed (col, row) pair to a row-major source index under the
// configured border mode, with a flag for zero padding.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle while the output is not stalled; the
// floor-mod runs down a chain of COORD_BITS remainder cells, one magnitude
// bit per cell, two axes side by side, between the input and map stages.
// Reset: all valid stages clear at once, border mode goes to clamp to edge and
// width and height to 4096. No clearing pass.
// ----------------------------------------------------------------------------
module image_border_address_core #(
    parameter int MAX_DIM    = iba_pkg::IBA_MAX_DIM_DEF,
    parameter int COORD_BITS = iba_pkg::IBA_COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [iba_pkg::IBA_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [iba_pkg::IBA_CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  iba_pkg::iba_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output iba_pkg::iba_out_t                   m_data
);

    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int DIV_BITS = DIM_BITS + 1;
    localparam int IN_W     = iba_pkg::IBA_COORD_W;
    localparam int IDX_W    = iba_pkg::IBA_INDEX_W;
    localparam int SIZE_W   = iba_pkg::IBA_SIZE_W;
    localparam int PROD_W   = 2 * DIM_BITS + 1;

    // configuration
    iba_pkg::iba_mode_t  mode_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= iba_pkg::IBA_MODE_EDGE;
            width_reg  <= iba_pkg::IBA_SIZE_RST;
            height_reg <= iba_pkg::IBA_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                iba_pkg::IBA_REG_MODE: begin
                    mode_reg <= iba_pkg::iba_mode_t'(cfg_wr_data[1:0]);
                end
                iba_pkg::IBA_REG_WIDTH: begin
                    width_reg <= cfg_wr_data;
                end
                iba_pkg::IBA_REG_HEIGHT: begin
                    height_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    logic [31:0]         width32;
    logic [31:0]         height32;
    logic [31:0]         eff_w32;
    logic [31:0]         eff_h32;
    logic [DIM_BITS-1:0] eff_w;
    logic [DIM_BITS-1:0] eff_h;
    logic [DIV_BITS-1:0] div_w;
    logic [DIV_BITS-1:0] div_h;

    assign width32  = 32'(width_reg);
    assign height32 = 32'(height_reg);

    always_comb begin
        if (width32 == 32'd0) begin
            eff_w32 = 32'd1;
        end else if (width32 > 32'(MAX_DIM)) begin
            eff_w32 = 32'(MAX_DIM);
        end else begin
            eff_w32 = width32;
        end
        if (height32 == 32'd0) begin
            eff_h32 = 32'd1;
        end else if (height32 > 32'(MAX_DIM)) begin
            eff_h32 = 32'(MAX_DIM);
        end else begin
            eff_h32 = height32;
        end
    end

    assign eff_w = eff_w32[DIM_BITS-1:0];
    assign eff_h = eff_h32[DIM_BITS-1:0];
    assign div_w = (mode_reg == iba_pkg::IBA_MODE_REFLECT) ? {eff_w, 1'b0} : {1'b0, eff_w};
    assign div_h = (mode_reg == iba_pkg::IBA_MODE_REFLECT) ? {eff_h, 1'b0} : {1'b0, eff_h};

    // whole chain moves together when the output register is free or draining
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // input stage: sign and magnitude per axis
    logic [31:0]           col_raw;
    logic [31:0]           row_raw;
    logic [COORD_BITS-1:0] col_c;
    logic [COORD_BITS-1:0] row_c;
    logic [COORD_BITS-1:0] prep_col_mag_reg;
    logic [COORD_BITS-1:0] prep_row_mag_reg;
    logic                  prep_col_neg_reg;
    logic                  prep_row_neg_reg;

    assign col_raw = {{(32 - IN_W){1'b0}}, s_data.col};
    assign row_raw = {{(32 - IN_W){1'b0}}, s_data.row};
    assign col_c   = col_raw[COORD_BITS-1:0];
    assign row_c   = row_raw[COORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            prep_col_neg_reg <= col_c[COORD_BITS-1];
            prep_row_neg_reg <= row_c[COORD_BITS-1];
            prep_col_mag_reg <= col_c[COORD_BITS-1] ? (~col_c + 1'b1) : col_c;
            prep_row_mag_reg <= row_c[COORD_BITS-1] ? (~row_c + 1'b1) : row_c;
        end
    end

    // valid chain: input stage, cells, map stage
    logic [COORD_BITS+1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[COORD_BITS:0], s_valid};
        end
    end

    // remainder cell chain
    logic [COORD_BITS-1:0] col_mag [0:COORD_BITS];
    logic [COORD_BITS-1:0] row_mag [0:COORD_BITS];
    logic                  col_neg [0:COORD_BITS];
    logic                  row_neg [0:COORD_BITS];
    logic [DIV_BITS-1:0]   col_rem [0:COORD_BITS];
    logic [DIV_BITS-1:0]   row_rem [0:COORD_BITS];

    assign col_mag[0] = prep_col_mag_reg;
    assign row_mag[0] = prep_row_mag_reg;
    assign col_neg[0] = prep_col_neg_reg;
    assign row_neg[0] = prep_row_neg_reg;
    assign col_rem[0] = '0;
    assign row_rem[0] = '0;

    for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
        iba_cell #(
            .COORD_BITS (COORD_BITS),
            .DIV_BITS   (DIV_BITS),
            .BIT_POS    (COORD_BITS - 1 - k)
        ) u_col_cell (
            .aclk    (aclk),
            .en      (adv),
            .mag_in  (col_mag[k]),
            .neg_in  (col_neg[k]),
            .rem_in  (col_rem[k]),
            .divisor (div_w),
            .mag_out (col_mag[k+1]),
            .neg_out (col_neg[k+1]),
            .rem_out (col_rem[k+1])
        );

        iba_cell #(
            .COORD_BITS (COORD_BITS),
            .DIV_BITS   (DIV_BITS),
            .BIT_POS    (COORD_BITS - 1 - k)
        ) u_row_cell (
            .aclk    (aclk),
            .en      (adv),
            .mag_in  (row_mag[k]),
            .neg_in  (row_neg[k]),
            .rem_in  (row_rem[k]),
            .divisor (div_h),
            .mag_out (row_mag[k+1]),
            .neg_out (row_neg[k+1]),
            .rem_out (row_rem[k+1])
        );
    end

    // border mapping per axis
    logic [DIM_BITS-1:0] col_pos;
    logic [DIM_BITS-1:0] row_pos;
    logic                col_out;
    logic                row_out;

    iba_axis_map #(
        .COORD_BITS (COORD_BITS),
        .DIM_BITS   (DIM_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_col_map (
        .aclk        (aclk),
        .en          (adv),
        .mode        (mode_reg),
        .size        (eff_w),
        .divisor     (div_w),
        .mag         (col_mag[COORD_BITS]),
        .neg         (col_neg[COORD_BITS]),
        .rem         (col_rem[COORD_BITS]),
        .pos_out     (col_pos),
        .outside_out (col_out)
    );

    iba_axis_map #(
        .COORD_BITS (COORD_BITS),
        .DIM_BITS   (DIM_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_row_map (
        .aclk        (aclk),
        .en          (adv),
        .mode        (mode_reg),
        .size        (eff_h),
        .divisor     (div_h),
        .mag         (row_mag[COORD_BITS]),
        .neg         (row_neg[COORD_BITS]),
        .rem         (row_rem[COORD_BITS]),
        .pos_out     (row_pos),
        .outside_out (row_out)
    );

    // index and output register
    logic [PROD_W-1:0]   idx_full;
    logic                pad_next;
    iba_pkg::iba_out_t   out_reg;
    iba_pkg::iba_out_t   out_next;
    logic                m_valid_reg;

    assign idx_full = (PROD_W'(row_pos) * PROD_W'(eff_w)) + PROD_W'(col_pos);
    assign pad_next = (mode_reg == iba_pkg::IBA_MODE_ZERO) && (col_out || row_out);

    always_comb begin
        out_next.is_padding   = pad_next;
        out_next.source_index = pad_next ? '0 : IDX_W'(idx_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[COORD_BITS+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_pad_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_padding) |-> (m_data.source_index == '0))
        else $error("padding result with nonzero index");

    a_map_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[COORD_BITS+1]) |=> m_valid)
        else $error("mapped item lost before output register");

    a_stall_holds_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

FILE: hw/rtl/iba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iba_cell
// One remainder step: shifts in one magnitude bit and subtracts the divisor
// when it fits, then registers the axis data for the next cell.
// ----------------------------------------------------------------------------
module iba_cell #(
    parameter int COORD_BITS = 16,
    parameter int DIV_BITS   = 14,
    parameter int BIT_POS    = 15
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] mag_in,
    input  logic                  neg_in,
    input  logic [DIV_BITS-1:0]   rem_in,
    input  logic [DIV_BITS-1:0]   divisor,
    output logic [COORD_BITS-1:0] mag_out,
    output logic                  neg_out,
    output logic [DIV_BITS-1:0]   rem_out
);

    logic [COORD_BITS-1:0] mag_reg;
    logic                  neg_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   rem_next;
    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;

    assign trial = {rem_in, mag_in[BIT_POS]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        if (trial >= {1'b0, divisor}) begin
            rem_next = diff[DIV_BITS-1:0];
        end else begin
            rem_next = trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_in;
            neg_reg <= neg_in;
            rem_reg <= rem_next;
        end
    end

    assign mag_out = mag_reg;
    assign neg_out = neg_reg;
    assign rem_out = rem_reg;

endmodule

FILE: hw/rtl/iba_axis_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iba_axis_map
// Turns the remainder of one axis, or its clamped coordinate in zero and edge
// modes, into the in-image position and flags a coordinate outside the image.
// ----------------------------------------------------------------------------
module iba_axis_map #(
    parameter int COORD_BITS = 16,
    parameter int DIM_BITS   = 13,
    parameter int DIV_BITS   = 14
) (
    input  logic                  aclk,
    input  logic                  en,
    input  iba_pkg::iba_mode_t    mode,
    input  logic [DIM_BITS-1:0]   size,
    input  logic [DIV_BITS-1:0]   divisor,
    input  logic [COORD_BITS-1:0] mag,
    input  logic                  neg,
    input  logic [DIV_BITS-1:0]   rem,
    output logic [DIM_BITS-1:0]   pos_out,
    output logic                  outside_out
);

    localparam int CMP_W = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    logic [DIM_BITS-1:0] pos_reg;
    logic [DIM_BITS-1:0] pos_next;
    logic                outside_reg;
    logic                outside;
    logic [DIM_BITS-1:0] size_m1;
    logic [DIM_BITS-1:0] clamp;
    logic [DIV_BITS-1:0] wrap;
    logic [DIV_BITS-1:0] refl;

    assign outside = neg || (CMP_W'(mag) >= CMP_W'(size));
    assign size_m1 = size - 1'b1;

    always_comb begin
        if (neg) begin
            clamp = '0;
        end else if (outside) begin
            clamp = size_m1;
        end else begin
            clamp = DIM_BITS'(mag);
        end

        if (neg && (rem != '0)) begin
            wrap = divisor - rem;
        end else begin
            wrap = rem;
        end

        if (wrap >= DIV_BITS'(size)) begin
            refl = divisor - 1'b1 - wrap;
        end else begin
            refl = wrap;
        end

        unique case (mode)
            iba_pkg::IBA_MODE_REPEAT: begin
                pos_next = DIM_BITS'(wrap);
            end
            iba_pkg::IBA_MODE_REFLECT: begin
                pos_next = DIM_BITS'(refl);
            end
            iba_pkg::IBA_MODE_ZERO, iba_pkg::IBA_MODE_EDGE: begin
                pos_next = clamp;
            end
            default: begin
                pos_next = clamp;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg     <= pos_next;
            outside_reg <= outside;
        end
    end

    assign pos_out     = pos_reg;
    assign outside_out = outside_reg;

endmodule

FILE: tb/image_border_address_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_border_address_checker
// Passive monitor for the image border address core. It keeps its own copy of
// the border registers and predicts the source index and padding flag of each
// input transfer. Each result transfer is compared in order against those
// predictions.
// ----------------------------------------------------------------------------
module image_border_address_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [iba_pkg::IBA_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [iba_pkg::IBA_CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  iba_pkg::iba_in_t                    s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  iba_pkg::iba_out_t                   m_data,
    output int                                  fail_count,
    output int                                  pending_count
);
    import iba_pkg::*;

    iba_mode_t              cur_mode;
    logic [IBA_SIZE_W-1:0]  cur_width;
    logic [IBA_SIZE_W-1:0]  cur_height;
    iba_out_t               expected_addr_q[$];

    function automatic int clip_size(logic [IBA_SIZE_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > IBA_MAX_DIM_DEF) return IBA_MAX_DIM_DEF;
        return int'(raw);
    endfunction

    function automatic int fold_axis(int c, int n, iba_mode_t mode);
        int m;
        case (mode)
            IBA_MODE_REPEAT: begin
                m = c % n;
                if (m < 0) m += n;
                return m;
            end
            IBA_MODE_REFLECT: begin
                m = c % (2 * n);
                if (m < 0) m += 2 * n;
                return (m >= n) ? (2 * n - 1 - m) : m;
            end
            default: begin
                if (c < 0) return 0;
                if (c > n - 1) return n - 1;
                return c;
            end
        endcase
    endfunction

    function automatic iba_out_t predict_address(iba_in_t px);
        int w, h, c, r, x, y;
        iba_out_t res;
        w = clip_size(cur_width);
        h = clip_size(cur_height);
        c = $signed(px.col);
        r = $signed(px.row);
        if (cur_mode == IBA_MODE_ZERO && (c < 0 || c >= w || r < 0 || r >= h)) begin
            res.source_index = '0;
            res.is_padding   = 1'b1;
            return res;
        end
        x = fold_axis(c, w, cur_mode);
        y = fold_axis(r, h, cur_mode);
        res.source_index = IBA_INDEX_W'(y * w + x);
        res.is_padding   = 1'b0;
        return res;
    endfunction

    initial begin
        fail_count    = 0;
        pending_count = 0;
        cur_mode      = IBA_MODE_EDGE;
        cur_width     = IBA_SIZE_RST;
        cur_height    = IBA_SIZE_RST;
    end

    always @(posedge aclk) begin
        iba_out_t want;
        if (!aresetn) begin
            cur_mode   = IBA_MODE_EDGE;
            cur_width  = IBA_SIZE_RST;
            cur_height = IBA_SIZE_RST;
            expected_addr_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    IBA_REG_MODE:   cur_mode   = iba_mode_t'(cfg_wr_data[1:0]);
                    IBA_REG_WIDTH:  cur_width  = cfg_wr_data[IBA_SIZE_W-1:0];
                    IBA_REG_HEIGHT: cur_height = cfg_wr_data[IBA_SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_addr_q.push_back(predict_address(s_data));
            if (m_valid && m_ready) begin
                if (expected_addr_q.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    fail_count++;
                end else begin
                    want = expected_addr_q.pop_front();
                    if (m_data.source_index !== want.source_index) begin
                        $error("source_index: expected %0d, actual %0d",
                               want.source_index, m_data.source_index);
                        fail_count++;
                    end
                    if (m_data.is_padding !== want.is_padding) begin
                        $error("is_padding: expected %0b, actual %0b",
                               want.is_padding, m_data.is_padding);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_addr_q.size();
    end

endmodule

FILE: tb/image_border_address_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_border_address_core_tb
// Drives coordinate pairs into the border address core under a series of
// border modes and image sizes, directed corners first and then random
// phases, with random gaps on the input and random stalls on the output.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module image_border_address_core_tb;
    import iba_pkg::*;

    localparam int PIPE_LATENCY = IBA_COORD_BITS_DEF + 3;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
    localparam int NUM_PHASES   = 24;
    localparam int PHASE_ITEMS  = 52;
    localparam logic [IBA_CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                        aclk;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [IBA_CFG_ADDR_W-1:0]   cfg_addr    = '0;
    logic [IBA_CFG_DATA_W-1:0]   cfg_wr_data = '0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    iba_in_t                     s_data      = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    iba_out_t                    m_data;
    int                          fail_count;
    int                          pending_count;
    int                          gap_pct     = 0;
    int                          stall_pct   = 0;

    image_border_address_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    image_border_address_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side back-pressure
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (stall_pct != 0 && $urandom_range(0, 149) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(10, 40);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic int pick_gap();
        if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [IBA_SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'($urandom_range(4097, 8191));
            4, 5:    return 13'($urandom_range(1, 16));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic int pick_coord(logic [IBA_SIZE_W-1:0] raw);
        int n;
        n = (raw == 0) ? 1 : ((raw > IBA_MAX_DIM_DEF) ? IBA_MAX_DIM_DEF : int'(raw));
        case ($urandom_range(0, 9))
            0, 1: return int'($signed(16'($urandom)));
            2: begin
                case ($urandom_range(0, 3))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            3: begin
                case ($urandom_range(0, 7))
                    0:       return -1;
                    1:       return 0;
                    2:       return n - 1;
                    3:       return n;
                    4:       return 2 * n - 1;
                    5:       return 2 * n;
                    6:       return -n;
                    default: return -n - 1;
                endcase
            end
            default: return int'($urandom_range(0, 6 * n) - 3 * n);
        endcase
    endfunction

    task automatic send_coord(input int c, input int r);
        int gap;
        s_valid <= 1'b1;
        s_data  <= '{col: 16'(c), row: 16'(r)};
        do @(posedge aclk); while (!s_ready);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data  <= iba_in_t'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold off input until every predicted result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IBA_CFG_ADDR_W-1:0] idx,
                             input logic [IBA_CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input iba_mode_t mode, input logic [IBA_SIZE_W-1:0] w,
                              input logic [IBA_SIZE_W-1:0] h);
        write_reg(IBA_REG_MODE, {11'($urandom), mode});
        write_reg(IBA_REG_WIDTH, w);
        write_reg(IBA_REG_HEIGHT, h);
    endtask

    initial begin : stimulus
        iba_mode_t             mode;
        logic [IBA_SIZE_W-1:0] w, h;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: clamp to edge, 4096 x 4096
        gap_pct   = 20;
        stall_pct = 20;
        send_coord(0, 0);
        send_coord(-32768, 32767);
        send_coord(32767, -32768);
        send_coord(4095, 4096);
        drain_results();

        set_config(IBA_MODE_ZERO, 13'd5, 13'd3);
        send_coord(-1, 0);
        send_coord(5, 2);
        send_coord(0, 3);
        send_coord(4, 2);
        send_coord(0, -1);
        drain_results();

        // zero width reads as one, oversized height saturates
        set_config(IBA_MODE_REFLECT, 13'd0, 13'h1fff);
        send_coord(-32768, -32768);
        send_coord(32767, 32767);
        send_coord(-1, -4097);
        send_coord(1, 8191);
        drain_results();

        set_config(IBA_MODE_REPEAT, 13'd4097, 13'd1);
        send_coord(-1, -1);
        send_coord(4096, 5);
        send_coord(-4097, 32767);
        drain_results();

        // unmapped register index must not disturb anything
        write_reg(REG_UNUSED, 13'h1fff);
        send_coord(12345, -12345);
        send_coord(-2, -3);
        drain_results();

        set_config(IBA_MODE_EDGE, 13'd4096, 13'd4096);
        send_coord(4096, 4096);
        send_coord(-1, -1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin mode = IBA_MODE_ZERO;    w = 13'd1;    h = 13'd4096; end
                1: begin mode = IBA_MODE_EDGE;    w = 13'd4096; h = 13'd1;    end
                2: begin mode = IBA_MODE_REPEAT;  w = 13'h1fff; h = 13'd0;    end
                3: begin mode = IBA_MODE_REFLECT; w = 13'd1;    h = 13'd1;    end
                default: begin
                    mode = iba_mode_t'($urandom_range(0, 3));
                    w    = pick_size();
                    h    = pick_size();
                end
            endcase
            set_config(mode, w, h);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 13'($urandom));
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 20; stall_pct = 20; end
                2: begin gap_pct = 50; stall_pct = 10; end
                default: begin gap_pct = 10; stall_pct = 50; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_coord(pick_coord(w), pick_coord(h));
        end

        drain_results();
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/iba_pkg.sv
hw/rtl/iba_cell.sv
hw/rtl/iba_axis_map.sv
hw/rtl/image_border_address_core.sv
tb/image_border_address_checker.sv
tb/image_border_address_core_tb.sv
